FILE: src/gjk_simplex_closest_point_2d_defines.svh
// assertion macros for the simplex solver
`ifndef GJK_SIMPLEX_CLOSEST_POINT_2D_DEFINES_SVH
`define GJK_SIMPLEX_CLOSEST_POINT_2D_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define GJK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
	else $error(msg);

// next-cycle implication
`define GJK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
	else $error(msg);

`endif

FILE: src/gjk_pkg.sv
`timescale 1ns / 1ps
package gjk_pkg;

	typedef enum logic [2:0] {
		RGN_A   = 3'd0,
		RGN_B   = 3'd1,
		RGN_C   = 3'd2,
		RGN_AB  = 3'd3,
		RGN_BC  = 3'd4,
		RGN_CA  = 3'd5,
		RGN_ABC = 3'd6
	} region_t;

	typedef struct packed {
		logic    valid;
		region_t region;
		logic [1:0] kept;
	} ctl_t;

	typedef struct packed {
		logic pos;
		logic neg;
	} sgn_t;

endpackage

FILE: src/gjk_front.sv
`timescale 1ns / 1ps
module gjk_front #(
	parameter int COORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [1:0]                    vertex_count,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	output gjk_pkg::ctl_t                 ctl,
	output logic signed [COORD_BITS-1:0]  p0_x,
	output logic signed [COORD_BITS-1:0]  p0_y,
	output logic signed [COORD_BITS-1:0]  p1_x,
	output logic signed [COORD_BITS-1:0]  p1_y,
	output logic signed [COORD_BITS-1:0]  p2_x,
	output logic signed [COORD_BITS-1:0]  p2_y,
	output logic [2*COORD_BITS:0]         wgt,
	output logic [2*COORD_BITS+1:0]       den,
	output logic signed [COORD_BITS:0]    dx,
	output logic signed [COORD_BITS:0]    dy
);

	localparam int W  = COORD_BITS;
	localparam int D  = W + 1;
	localparam int PW = 2 * D;
	localparam int S  = PW + 1;
	localparam int WB = 2 * W + 1;
	localparam int DB = 2 * W + 2;

	// stage 1: operands and edge differences
	logic                vld_s1;
	logic [1:0]          cnt_s1;
	logic signed [W-1:0] vx_s1 [3];
	logic signed [W-1:0] vy_s1 [3];
	logic signed [D-1:0] dab_x_s1, dab_y_s1, dbc_x_s1, dbc_y_s1, dca_x_s1, dca_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s1   <= (vertex_count == 2'd0) ? 2'd1 : vertex_count;
		vx_s1[0] <= a_x;
		vy_s1[0] <= a_y;
		vx_s1[1] <= b_x;
		vy_s1[1] <= b_y;
		vx_s1[2] <= c_x;
		vy_s1[2] <= c_y;
		dab_x_s1 <= $signed({a_x[W-1], a_x}) - $signed({b_x[W-1], b_x});
		dab_y_s1 <= $signed({a_y[W-1], a_y}) - $signed({b_y[W-1], b_y});
		dbc_x_s1 <= $signed({b_x[W-1], b_x}) - $signed({c_x[W-1], c_x});
		dbc_y_s1 <= $signed({b_y[W-1], b_y}) - $signed({c_y[W-1], c_y});
		dca_x_s1 <= $signed({c_x[W-1], c_x}) - $signed({a_x[W-1], a_x});
		dca_y_s1 <= $signed({c_y[W-1], c_y}) - $signed({a_y[W-1], a_y});
	end

	// stage 2: products
	logic signed [D-1:0]  ex [3];
	logic signed [D-1:0]  ey [3];
	logic                 vld_s2;
	logic [1:0]           cnt_s2;
	logic signed [W-1:0]  vx_s2 [3];
	logic signed [W-1:0]  vy_s2 [3];
	logic signed [PW-1:0] m_s2 [20];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ex[i] = $signed({vx_s1[i][W-1], vx_s1[i]});
			ey[i] = $signed({vy_s1[i][W-1], vy_s1[i]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s2 <= cnt_s1;
		vx_s2  <= vx_s1;
		vy_s2  <= vy_s1;
		m_s2[0]  <= ex[0] * dab_x_s1;
		m_s2[1]  <= ey[0] * dab_y_s1;
		m_s2[2]  <= ex[1] * dab_x_s1;
		m_s2[3]  <= ey[1] * dab_y_s1;
		m_s2[4]  <= ex[1] * dbc_x_s1;
		m_s2[5]  <= ey[1] * dbc_y_s1;
		m_s2[6]  <= ex[2] * dbc_x_s1;
		m_s2[7]  <= ey[2] * dbc_y_s1;
		m_s2[8]  <= ex[2] * dca_x_s1;
		m_s2[9]  <= ey[2] * dca_y_s1;
		m_s2[10] <= ex[0] * dca_x_s1;
		m_s2[11] <= ey[0] * dca_y_s1;
		m_s2[12] <= ex[0] * ey[1];
		m_s2[13] <= ey[0] * ex[1];
		m_s2[14] <= ex[1] * ey[2];
		m_s2[15] <= ey[1] * ex[2];
		m_s2[16] <= ex[2] * ey[0];
		m_s2[17] <= ey[2] * ex[0];
		m_s2[18] <= dab_x_s1 * dca_y_s1;
		m_s2[19] <= dab_y_s1 * dca_x_s1;
	end

	// stage 3: dot sums and cross signs
	logic signed [S-1:0] dsum [6];
	logic signed [S-1:0] csum [4];
	logic                vld_s3;
	logic [1:0]          cnt_s3;
	logic signed [W-1:0] vx_s3 [3];
	logic signed [W-1:0] vy_s3 [3];
	logic signed [S-1:0] dot_s3 [6];
	gjk_pkg::sgn_t       sg_s3 [4];

	always_comb begin
		for (int k = 0; k < 6; k++) begin
			dsum[k] = S'(m_s2[2*k]) + S'(m_s2[2*k+1]);
		end
		for (int j = 0; j < 4; j++) begin
			csum[j] = S'(m_s2[12+2*j]) - S'(m_s2[13+2*j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		cnt_s3 <= cnt_s2;
		vx_s3  <= vx_s2;
		vy_s3  <= vy_s2;
		dot_s3 <= dsum;
		for (int j = 0; j < 3; j++) begin
			sg_s3[j].neg <= csum[j][S-1];
			sg_s3[j].pos <= !csum[j][S-1] && (csum[j] != '0);
		end
		// triangle orientation is the negated raw cross
		sg_s3[3].pos <= csum[3][S-1];
		sg_s3[3].neg <= !csum[3][S-1] && (csum[3] != '0);
	end

	// stage 4: region and reduced simplex
	gjk_pkg::region_t    rgn;
	logic                vab_le, uab_le, vbc_le, ubc_le, vca_le, uca_le;
	logic                sw_ok, su_ok, sv_ok;
	logic [1:0]          kept_c;
	logic signed [W-1:0] p0x, p0y, p1x, p1y, p2x, p2y;
	logic signed [S-1:0] w_c, den_c;

	always_comb begin
		vab_le = dot_s3[0][S-1] || (dot_s3[0] == '0);
		uab_le = !dot_s3[1][S-1];
		vbc_le = dot_s3[2][S-1] || (dot_s3[2] == '0);
		ubc_le = !dot_s3[3][S-1];
		vca_le = dot_s3[4][S-1] || (dot_s3[4] == '0);
		uca_le = !dot_s3[5][S-1];
		sw_ok  = !((sg_s3[0].pos && sg_s3[3].pos) || (sg_s3[0].neg && sg_s3[3].neg));
		su_ok  = !((sg_s3[1].pos && sg_s3[3].pos) || (sg_s3[1].neg && sg_s3[3].neg));
		sv_ok  = !((sg_s3[2].pos && sg_s3[3].pos) || (sg_s3[2].neg && sg_s3[3].neg));
		case (cnt_s3)
			2'd2: begin
				if (vab_le) rgn = gjk_pkg::RGN_A;
				else if (uab_le) rgn = gjk_pkg::RGN_B;
				else rgn = gjk_pkg::RGN_AB;
			end
			2'd3: begin
				if (vab_le && uca_le) rgn = gjk_pkg::RGN_A;
				else if (uab_le && vbc_le) rgn = gjk_pkg::RGN_B;
				else if (ubc_le && vca_le) rgn = gjk_pkg::RGN_C;
				else if (!uab_le && !vab_le && sw_ok) rgn = gjk_pkg::RGN_AB;
				else if (!ubc_le && !vbc_le && su_ok) rgn = gjk_pkg::RGN_BC;
				else if (!uca_le && !vca_le && sv_ok) rgn = gjk_pkg::RGN_CA;
				else rgn = gjk_pkg::RGN_ABC;
			end
			default: rgn = gjk_pkg::RGN_A;
		endcase

		kept_c = 2'd1;
		p0x = vx_s3[0];
		p0y = vy_s3[0];
		p1x = '0;
		p1y = '0;
		p2x = '0;
		p2y = '0;
		w_c   = dot_s3[0];
		den_c = dot_s3[0] - dot_s3[1];
		case (rgn)
			gjk_pkg::RGN_A: begin
				p0x = vx_s3[0];
				p0y = vy_s3[0];
			end
			gjk_pkg::RGN_B: begin
				p0x = vx_s3[1];
				p0y = vy_s3[1];
			end
			gjk_pkg::RGN_C: begin
				p0x = vx_s3[2];
				p0y = vy_s3[2];
			end
			gjk_pkg::RGN_AB: begin
				kept_c = 2'd2;
				p1x = vx_s3[1];
				p1y = vy_s3[1];
			end
			gjk_pkg::RGN_BC: begin
				kept_c = 2'd2;
				p0x = vx_s3[1];
				p0y = vy_s3[1];
				p1x = vx_s3[2];
				p1y = vy_s3[2];
				w_c   = dot_s3[2];
				den_c = dot_s3[2] - dot_s3[3];
			end
			gjk_pkg::RGN_CA: begin
				kept_c = 2'd2;
				p0x = vx_s3[2];
				p0y = vy_s3[2];
				p1x = vx_s3[0];
				p1y = vy_s3[0];
				w_c   = dot_s3[4];
				den_c = dot_s3[4] - dot_s3[5];
			end
			gjk_pkg::RGN_ABC: begin
				kept_c = 2'd3;
				p1x = vx_s3[1];
				p1y = vy_s3[1];
				p2x = vx_s3[2];
				p2y = vy_s3[2];
			end
			default: begin
				kept_c = 2'd1;
			end
		endcase
	end

	gjk_pkg::ctl_t ctl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4.valid  <= vld_s3;
			ctl_s4.region <= rgn;
			ctl_s4.kept   <= kept_c;
		end
	end

	logic signed [W-1:0] p0x_s4, p0y_s4, p1x_s4, p1y_s4, p2x_s4, p2y_s4;
	logic [WB-1:0]       wgt_s4;
	logic [DB-1:0]       den_s4;
	logic signed [D-1:0] dx_s4, dy_s4;

	always_ff @(posedge clk) begin
		p0x_s4 <= p0x;
		p0y_s4 <= p0y;
		p1x_s4 <= p1x;
		p1y_s4 <= p1y;
		p2x_s4 <= p2x;
		p2y_s4 <= p2y;
		wgt_s4 <= w_c[WB-1:0];
		den_s4 <= den_c[DB-1:0];
		dx_s4  <= $signed({p1x[W-1], p1x}) - $signed({p0x[W-1], p0x});
		dy_s4  <= $signed({p1y[W-1], p1y}) - $signed({p0y[W-1], p0y});
	end

	assign ctl  = ctl_s4;
	assign p0_x = p0x_s4;
	assign p0_y = p0y_s4;
	assign p1_x = p1x_s4;
	assign p1_y = p1y_s4;
	assign p2_x = p2x_s4;
	assign p2_y = p2y_s4;
	assign wgt  = wgt_s4;
	assign den  = den_s4;
	assign dx   = dx_s4;
	assign dy   = dy_s4;

endmodule

FILE: src/gjk_div_axis.sv
`timescale 1ns / 1ps
module gjk_div_axis #(
	parameter int COORD_BITS = 32
) (
	input  logic                          clk,
	input  logic [2*COORD_BITS:0]         wgt,
	input  logic [2*COORD_BITS+1:0]       den,
	input  logic signed [COORD_BITS:0]    diff,
	input  logic signed [COORD_BITS-1:0]  base,
	output logic signed [COORD_BITS-1:0]  near
);

	localparam int W  = COORD_BITS;
	localparam int WB = 2 * W + 1;
	localparam int DB = 2 * W + 2;
	localparam int QB = W + 1;
	localparam int TW = 3 * W + 4;
	localparam int MW = TW - 1;
	localparam int RB = DB + 1;

	// split product of weight and edge difference
	logic signed [2*W+2:0] pl_s1;
	logic signed [2*W+1:0] ph_s1;
	logic [DB-1:0]         den_s1, den_s2, den_s3;
	logic signed [W-1:0]   base_s1, base_s2, base_s3;

	always_ff @(posedge clk) begin
		pl_s1   <= $signed({1'b0, wgt[W:0]}) * diff;
		ph_s1   <= $signed({1'b0, wgt[WB-1:W+1]}) * diff;
		den_s1  <= den;
		base_s1 <= base;
	end

	logic signed [TW-1:0] num_s2;

	always_ff @(posedge clk) begin
		num_s2  <= (TW'(ph_s1) <<< (W + 1)) + TW'(pl_s1);
		den_s2  <= den_s1;
		base_s2 <= base_s1;
	end

	// rounding bias: 2*num + den over 2*den
	logic signed [TW-1:0] t_s3;

	always_ff @(posedge clk) begin
		t_s3    <= (num_s2 <<< 1) + $signed({{(TW-DB){1'b0}}, den_s2});
		den_s3  <= den_s2;
		base_s3 <= base_s2;
	end

	logic [TW-1:0]       mag;
	logic [RB-1:0]       rem_dv  [QB+1];
	logic [QB-1:0]       low_dv  [QB+1];
	logic [QB-1:0]       quo_dv  [QB+1];
	logic [RB-1:0]       d2_dv   [QB+1];
	logic                neg_dv  [QB+1];
	logic signed [W-1:0] base_dv [QB+1];

	assign mag = t_s3[TW-1] ? TW'(-t_s3) : TW'(t_s3);

	always_ff @(posedge clk) begin
		rem_dv[0]  <= {1'b0, mag[MW-1:QB]};
		low_dv[0]  <= mag[QB-1:0];
		quo_dv[0]  <= '0;
		d2_dv[0]   <= {den_s3, 1'b0};
		neg_dv[0]  <= t_s3[TW-1];
		base_dv[0] <= base_s3;
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [RB:0] trial;
		logic [RB:0] sub;
		logic        ge;

		always_comb begin
			trial = {rem_dv[k], low_dv[k][QB-1]};
			sub   = trial - {1'b0, d2_dv[k]};
			ge    = trial >= {1'b0, d2_dv[k]};
		end

		always_ff @(posedge clk) begin
			rem_dv[k+1]  <= ge ? sub[RB-1:0] : trial[RB-1:0];
			low_dv[k+1]  <= low_dv[k] << 1;
			quo_dv[k+1]  <= {quo_dv[k][QB-2:0], ge};
			d2_dv[k+1]   <= d2_dv[k];
			neg_dv[k+1]  <= neg_dv[k];
			base_dv[k+1] <= base_dv[k];
		end
	end

	// floor for negative numerators
	logic [QB:0]           qq;
	logic signed [QB+1:0]  qs_f1;
	logic signed [W-1:0]   base_f1;

	assign qq = {1'b0, quo_dv[QB]}
		+ (QB+1)'(neg_dv[QB] && (rem_dv[QB] != '0));

	always_ff @(posedge clk) begin
		qs_f1   <= neg_dv[QB] ? -$signed({1'b0, qq}) : $signed({1'b0, qq});
		base_f1 <= base_dv[QB];
	end

	logic signed [W+2:0] sum;
	logic signed [W+2:0] hi_lim;
	logic signed [W+2:0] lo_lim;
	logic signed [W-1:0] near_f2;

	always_comb begin
		sum    = (W+3)'(base_f1) + (W+3)'(qs_f1);
		hi_lim = (W+3)'($signed({1'b0, {(W-1){1'b1}}}));
		lo_lim = (W+3)'($signed({1'b1, {(W-1){1'b0}}}));
	end

	always_ff @(posedge clk) begin
		if (sum > hi_lim) begin
			near_f2 <= hi_lim[W-1:0];
		end else if (sum < lo_lim) begin
			near_f2 <= lo_lim[W-1:0];
		end else begin
			near_f2 <= sum[W-1:0];
		end
	end

	assign near = near_f2;

endmodule

FILE: src/gjk_simplex_closest_point_2d.sv
// channel  words                                            handshake
// in       vertex_count, a_x, a_y, b_x, b_y, c_x, c_y       start, busy
// out      kept_count, p0_x..p2_y, near_x, near_y,          done
//          holds_origin, region
//
// one word per cycle; busy stays low
// start reaches done through the front stages, the restoring divider that
//   resolves one quotient bit per pipeline stage, and the output registers
// reset clears the valid bits and control words only
// done pulses for one cycle; results flow without backpressure
`timescale 1ns / 1ps
`include "gjk_simplex_closest_point_2d_defines.svh"
module gjk_simplex_closest_point_2d #(
	parameter int COORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    vertex_count,
	input  logic signed [COORD_BITS-1:0]  a_x,
	input  logic signed [COORD_BITS-1:0]  a_y,
	input  logic signed [COORD_BITS-1:0]  b_x,
	input  logic signed [COORD_BITS-1:0]  b_y,
	input  logic signed [COORD_BITS-1:0]  c_x,
	input  logic signed [COORD_BITS-1:0]  c_y,
	output logic                          done,
	output logic [1:0]                    kept_count,
	output logic signed [COORD_BITS-1:0]  p0_x,
	output logic signed [COORD_BITS-1:0]  p0_y,
	output logic signed [COORD_BITS-1:0]  p1_x,
	output logic signed [COORD_BITS-1:0]  p1_y,
	output logic signed [COORD_BITS-1:0]  p2_x,
	output logic signed [COORD_BITS-1:0]  p2_y,
	output logic signed [COORD_BITS-1:0]  near_x,
	output logic signed [COORD_BITS-1:0]  near_y,
	output logic                          holds_origin,
	output logic [2:0]                    region
);

	localparam int W         = COORD_BITS;
	localparam int AXIS_LAT  = W + 7;
	localparam int TOTAL_LAT = AXIS_LAT + 5;

	typedef struct packed {
		logic signed [W-1:0] p0x;
		logic signed [W-1:0] p0y;
		logic signed [W-1:0] p1x;
		logic signed [W-1:0] p1y;
		logic signed [W-1:0] p2x;
		logic signed [W-1:0] p2y;
	} side_t;

	gjk_pkg::ctl_t       f_ctl;
	side_t               f_side;
	logic [2*W:0]        f_wgt;
	logic [2*W+1:0]      f_den;
	logic signed [W:0]   f_dx, f_dy;
	logic signed [W-1:0] ax_near, ay_near;

	assign busy = 1'b0;

	gjk_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.vertex_count (vertex_count),
		.a_x          (a_x),
		.a_y          (a_y),
		.b_x          (b_x),
		.b_y          (b_y),
		.c_x          (c_x),
		.c_y          (c_y),
		.ctl          (f_ctl),
		.p0_x         (f_side.p0x),
		.p0_y         (f_side.p0y),
		.p1_x         (f_side.p1x),
		.p1_y         (f_side.p1y),
		.p2_x         (f_side.p2x),
		.p2_y         (f_side.p2y),
		.wgt          (f_wgt),
		.den          (f_den),
		.dx           (f_dx),
		.dy           (f_dy)
	);

	gjk_div_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
		.clk  (clk),
		.wgt  (f_wgt),
		.den  (f_den),
		.diff (f_dx),
		.base (f_side.p0x),
		.near (ax_near)
	);

	gjk_div_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
		.clk  (clk),
		.wgt  (f_wgt),
		.den  (f_den),
		.diff (f_dy),
		.base (f_side.p0y),
		.near (ay_near)
	);

	// side words ride alongside the dividers
	gjk_pkg::ctl_t ctl_dly_q  [AXIS_LAT];
	side_t         side_dly_q [AXIS_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXIS_LAT; i++) begin
				ctl_dly_q[i] <= '0;
			end
		end else begin
			ctl_dly_q[0] <= f_ctl;
			for (int i = 1; i < AXIS_LAT; i++) begin
				ctl_dly_q[i] <= ctl_dly_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_dly_q[0] <= f_side;
		for (int i = 1; i < AXIS_LAT; i++) begin
			side_dly_q[i] <= side_dly_q[i-1];
		end
	end

	gjk_pkg::ctl_t       c_end;
	side_t               s_end;
	logic                on_edge;
	logic                interior;
	logic signed [W-1:0] nx, ny;

	always_comb begin
		c_end    = ctl_dly_q[AXIS_LAT-1];
		s_end    = side_dly_q[AXIS_LAT-1];
		on_edge  = (c_end.region == gjk_pkg::RGN_AB) || (c_end.region == gjk_pkg::RGN_BC)
			|| (c_end.region == gjk_pkg::RGN_CA);
		interior = c_end.region == gjk_pkg::RGN_ABC;
		if (on_edge) begin
			nx = ax_near;
			ny = ay_near;
		end else if (interior) begin
			nx = '0;
			ny = '0;
		end else begin
			nx = s_end.p0x;
			ny = s_end.p0y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= c_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		kept_count   <= c_end.kept;
		region       <= c_end.region;
		holds_origin <= interior;
		p0_x         <= s_end.p0x;
		p0_y         <= s_end.p0y;
		p1_x         <= s_end.p1x;
		p1_y         <= s_end.p1y;
		p2_x         <= s_end.p2x;
		p2_y         <= s_end.p2y;
		near_x       <= nx;
		near_y       <= ny;
	end

	`GJK_ASSERT_NXT(a_latency, start, ##(TOTAL_LAT-1) done, "word lost in pipeline")
	`GJK_ASSERT_IMP(a_no_extra, done, $past(start, TOTAL_LAT), "result without a start")
	`GJK_ASSERT_IMP(a_interior, done && holds_origin, (near_x == '0 && near_y == '0 && kept_count == 2'd3 && region == gjk_pkg::RGN_ABC), "interior word malformed")
	`GJK_ASSERT_IMP(a_vertex, done && (region == gjk_pkg::RGN_A || region == gjk_pkg::RGN_B || region == gjk_pkg::RGN_C), (kept_count == 2'd1 && near_x == p0_x && near_y == p0_y && !holds_origin), "vertex word malformed")

endmodule

FILE: sim/tb_gjk_simplex_closest_point_2d.sv
`timescale 1ns / 1ps
module tb_gjk_simplex_closest_point_2d;
	import gjk_pkg::*;

	typedef logic signed [159:0] wide_t;
	localparam wide_t COORD_MAX = 160'sd2147483647;
	localparam wide_t COORD_MIN = -160'sd2147483648;
	localparam logic signed [31:0] C_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] C_MIN = 32'sh80000000;

	typedef struct {
		logic [1:0]        cnt;
		logic signed [31:0] x[3];
		logic signed [31:0] y[3];
	} simplex_t;

	typedef struct {
		logic [1:0]        kept;
		logic signed [31:0] px[3];
		logic signed [31:0] py[3];
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic              hold;
		region_t           rgn;
	} reduced_t;

	logic clk, arst_n, start, busy, done, holds_origin;
	logic [1:0] vertex_count, kept_count;
	logic signed [31:0] a_x, a_y, b_x, b_y, c_x, c_y;
	logic signed [31:0] p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, near_x, near_y;
	logic [2:0] region;

	simplex_t pending[$];
	reduced_t expected[$];
	simplex_t cur;
	int gap_left;
	int fails;

	gjk_simplex_closest_point_2d dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.vertex_count(vertex_count), .a_x(a_x), .a_y(a_y), .b_x(b_x), .b_y(b_y),
		.c_x(c_x), .c_y(c_y), .done(done), .kept_count(kept_count),
		.p0_x(p0_x), .p0_y(p0_y), .p1_x(p1_x), .p1_y(p1_y), .p2_x(p2_x), .p2_y(p2_y),
		.near_x(near_x), .near_y(near_y), .holds_origin(holds_origin), .region(region)
	);

	function automatic wide_t dot2(wide_t ax, wide_t ay, wide_t bx, wide_t by);
		return ax * bx + ay * by;
	endfunction

	function automatic int sgn(wide_t v);
		return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
	endfunction

	// p0 + round-half-up(w * (p1 - p0) / den), saturated
	function automatic logic signed [31:0] edge_pt(wide_t p0, wide_t p1, wide_t wt, wide_t den);
		wide_t num, t, d2, q, rr;
		num = wt * (p1 - p0);
		t = 2 * num + den;
		d2 = 2 * den;
		if (t < 0)
			q = -((-t + d2 - 1) / d2);
		else
			q = t / d2;
		rr = p0 + q;
		if (rr > COORD_MAX)
			rr = COORD_MAX;
		if (rr < COORD_MIN)
			rr = COORD_MIN;
		return rr[31:0];
	endfunction

	function automatic reduced_t solve_simplex(simplex_t s);
		wide_t vx[3], vy[3];
		wide_t uab, vab, ubc, vbc, uca, vca, wgt, den;
		int sa, su, sv, sw, cnt, e0, e1, k;
		int idx[3];
		region_t rg;
		reduced_t r;
		for (k = 0; k < 3; k++) begin
			vx[k] = s.x[k];
			vy[k] = s.y[k];
			r.px[k] = '0;
			r.py[k] = '0;
			idx[k] = k;
		end
		cnt = (s.cnt == 0) ? 1 : s.cnt;
		wgt = 0;
		rg = RGN_A;
		uab = dot2(-vx[1], -vy[1], vx[0] - vx[1], vy[0] - vy[1]);
		vab = dot2(-vx[0], -vy[0], vx[1] - vx[0], vy[1] - vy[0]);
		ubc = dot2(-vx[2], -vy[2], vx[1] - vx[2], vy[1] - vy[2]);
		vbc = dot2(-vx[1], -vy[1], vx[2] - vx[1], vy[2] - vy[1]);
		uca = dot2(-vx[0], -vy[0], vx[2] - vx[0], vy[2] - vy[0]);
		vca = dot2(-vx[2], -vy[2], vx[0] - vx[2], vy[0] - vy[2]);
		sa = sgn((vx[1] - vx[0]) * (vy[2] - vy[0]) - (vy[1] - vy[0]) * (vx[2] - vx[0]));
		su = sgn(vx[1] * vy[2] - vy[1] * vx[2]);
		sv = sgn(vx[2] * vy[0] - vy[2] * vx[0]);
		sw = sgn(vx[0] * vy[1] - vy[0] * vx[1]);
		if (cnt == 2) begin
			if (vab <= 0)
				rg = RGN_A;
			else if (uab <= 0)
				rg = RGN_B;
			else begin
				rg = RGN_AB;
				wgt = vab;
			end
		end else if (cnt == 3) begin
			if (vab <= 0 && uca <= 0)
				rg = RGN_A;
			else if (uab <= 0 && vbc <= 0)
				rg = RGN_B;
			else if (ubc <= 0 && vca <= 0)
				rg = RGN_C;
			else if (uab > 0 && vab > 0 && sw * sa <= 0) begin
				rg = RGN_AB;
				wgt = vab;
			end else if (ubc > 0 && vbc > 0 && su * sa <= 0) begin
				rg = RGN_BC;
				wgt = vbc;
			end else if (uca > 0 && vca > 0 && sv * sa <= 0) begin
				rg = RGN_CA;
				wgt = vca;
			end else
				rg = RGN_ABC;
		end
		r.rgn = rg;
		r.hold = 1'b0;
		r.nx = '0;
		r.ny = '0;
		if (rg inside {RGN_A, RGN_B, RGN_C}) begin
			r.kept = 2'd1;
			idx[0] = int'(rg);
			r.nx = s.x[idx[0]];
			r.ny = s.y[idx[0]];
		end else if (rg != RGN_ABC) begin
			r.kept = 2'd2;
			if (rg == RGN_AB) begin
				e0 = 0; e1 = 1;
			end else if (rg == RGN_BC) begin
				e0 = 1; e1 = 2;
			end else begin
				e0 = 2; e1 = 0;
			end
			idx[0] = e0;
			idx[1] = e1;
			den = dot2(vx[e1] - vx[e0], vy[e1] - vy[e0], vx[e1] - vx[e0], vy[e1] - vy[e0]);
			r.nx = edge_pt(vx[e0], vx[e1], wgt, den);
			r.ny = edge_pt(vy[e0], vy[e1], wgt, den);
		end else begin
			r.kept = 2'd3;
			r.hold = 1'b1;
		end
		for (k = 0; k < r.kept; k++) begin
			r.px[k] = s.x[idx[k]];
			r.py[k] = s.y[idx[k]];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] rnd_coord(int mode);
		case (mode)
			0: return $signed($urandom());
			1: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
			2: return ($urandom_range(0, 1) != 0) ? C_MAX - $urandom_range(0, 3)
				: C_MIN + $urandom_range(0, 3);
			default: return $signed($urandom_range(0, 64)) - 32'sd32;
		endcase
	endfunction

	function automatic simplex_t mk(logic [1:0] n, logic signed [31:0] ax, logic signed [31:0] ay,
			logic signed [31:0] bx, logic signed [31:0] by, logic signed [31:0] cx,
			logic signed [31:0] cy);
		simplex_t s;
		s.cnt = n;
		s.x[0] = ax; s.y[0] = ay;
		s.x[1] = bx; s.y[1] = by;
		s.x[2] = cx; s.y[2] = cy;
		return s;
	endfunction

	task automatic chk(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			$error("%s: expected %h, got %h", nm, e, a);
			fails++;
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			vertex_count <= '0;
			a_x <= '0; a_y <= '0; b_x <= '0; b_y <= '0; c_x <= '0; c_y <= '0;
			gap_left <= 0;
		end else begin
			if (start && !busy)
				expected.push_back(solve_simplex(cur));
			if (start && busy) begin
			end else if (gap_left > 0) begin
				start <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending.size() > 0) begin
				cur = pending.pop_front();
				vertex_count <= cur.cnt;
				a_x <= cur.x[0]; a_y <= cur.y[0];
				b_x <= cur.x[1]; b_y <= cur.y[1];
				c_x <= cur.x[2]; c_y <= cur.y[2];
				start <= 1'b1;
				gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
			end else
				start <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk) begin
		reduced_t e;
		if (arst_n && done) begin
			if (expected.size() == 0) begin
				$error("unexpected word from dut");
				fails++;
			end else begin
				e = expected.pop_front();
				chk("kept_count", e.kept, kept_count);
				chk("p0_x", e.px[0], p0_x);
				chk("p0_y", e.py[0], p0_y);
				chk("p1_x", e.px[1], p1_x);
				chk("p1_y", e.py[1], p1_y);
				chk("p2_x", e.px[2], p2_x);
				chk("p2_y", e.py[2], p2_y);
				chk("near_x", e.nx, near_x);
				chk("near_y", e.ny, near_y);
				chk("holds_origin", e.hold, holds_origin);
				chk("region", e.rgn, region);
			end
		end
	end

	initial begin
		int i, m, burst;
		logic signed [31:0] q;
		fails = 0;
		arst_n = 1'b0;
		// directed
		pending.push_back(mk(2'd0, 32'sd5, -32'sd7, 32'sd1, 32'sd1, 32'sd1, 32'sd1));
		pending.push_back(mk(2'd1, C_MAX, C_MIN, 32'sd0, 32'sd0, 32'sd0, 32'sd0));
		pending.push_back(mk(2'd1, C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN));
		pending.push_back(mk(2'd2, 32'sd100, 32'sd100, 32'sd100, 32'sd100, 0, 0));
		pending.push_back(mk(2'd2, 32'sd100, 32'sd5, 32'sd200, 32'sd5, 0, 0));
		pending.push_back(mk(2'd2, 32'sd200, 32'sd5, 32'sd100, 32'sd5, 0, 0));
		pending.push_back(mk(2'd2, -32'sd100, 32'sd5, 32'sd100, 32'sd6, 0, 0));
		pending.push_back(mk(2'd2, C_MIN, C_MAX, C_MAX, C_MIN, 0, 0));
		pending.push_back(mk(2'd2, C_MIN, C_MIN, C_MAX, C_MIN, 0, 0));
		pending.push_back(mk(2'd2, C_MAX, C_MAX, C_MIN, C_MAX, 0, 0));
		pending.push_back(mk(2'd2, -32'sd1, 32'sd1, 32'sd2, 32'sd1, 0, 0));
		pending.push_back(mk(2'd3, -32'sd10, -32'sd10, 32'sd10, -32'sd10, 32'sd0, 32'sd10));
		pending.push_back(mk(2'd3, 32'sd10, 32'sd10, 32'sd20, 32'sd10, 32'sd10, 32'sd20));
		pending.push_back(mk(2'd3, 32'sd20, 32'sd10, 32'sd10, 32'sd10, 32'sd10, 32'sd20));
		pending.push_back(mk(2'd3, 32'sd20, 32'sd10, 32'sd10, 32'sd20, 32'sd10, 32'sd10));
		pending.push_back(mk(2'd3, -32'sd10, 32'sd5, 32'sd10, 32'sd5, 32'sd0, 32'sd20));
		pending.push_back(mk(2'd3, 32'sd0, 32'sd20, -32'sd10, 32'sd5, 32'sd10, 32'sd5));
		pending.push_back(mk(2'd3, 32'sd10, 32'sd5, 32'sd0, 32'sd20, -32'sd10, 32'sd5));
		pending.push_back(mk(2'd3, -32'sd10, 32'sd5, 32'sd0, 32'sd5, 32'sd10, 32'sd5));
		pending.push_back(mk(2'd3, -32'sd10, -32'sd10, 32'sd10, 32'sd10, 32'sd0, 32'sd0));
		pending.push_back(mk(2'd3, C_MIN, C_MIN, C_MAX, C_MIN, 32'sd0, C_MAX));
		pending.push_back(mk(2'd3, C_MIN, C_MAX, C_MAX, C_MAX, 32'sd0, C_MAX - 1));
		pending.push_back(mk(2'd3, 32'sd7, 32'sd7, 32'sd7, 32'sd7, 32'sd7, 32'sd7));
		// random
		for (i = 0; i < 1800; i++) begin
			m = $urandom_range(0, 9);
			if (m < 3) begin
				// triangle around the origin with a random scale
				q = $urandom_range(1, 32'h3fffffff);
				pending.push_back(mk(2'd3, -q + rnd_coord(3), -q + rnd_coord(3),
					q + rnd_coord(3), -q + rnd_coord(3), rnd_coord(3), q));
			end else begin
				burst = (m < 6) ? 1 : ((m < 8) ? 0 : 2);
				if (m == 9)
					burst = $urandom_range(0, 3);
				pending.push_back(mk(2'($urandom_range(0, 3)), rnd_coord(burst),
					rnd_coord(burst), rnd_coord(burst), rnd_coord(burst),
					rnd_coord(burst), rnd_coord(burst)));
			end
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending.size() == 0 && start == 1'b0 && expected.size() == 0);
		repeat (60) @(posedge clk);
		if (fails == 0 && expected.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

endmodule
